// ===== rtl/core/mtsl_pkg.sv =====
// shared types and codes for the two-list merge block
`timescale 1ns / 1ps

package mtsl_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 2;

    localparam logic [OPCODE_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MERGE         = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

endpackage

// ===== rtl/core/merge_two_sorted_lists.sv =====
// top level of the two-list merge block: two list memories and the sequencer
//
//  channel | ports                     | contents
//  --------+---------------------------+------------------------------------------
//  input   | s_tvalid/s_tready         | s_tuser[1:0] opcode, s_tdata[31:0] value
//  result  | m_tvalid/m_tready         | m_tdata[31:0] merged_value, m_tlast last
//
//  an append transfer writes one word into its list memory unless that list is full
//  a merge emits first_count + second_count results, the first registered in the merge
//  state that follows the merge transfer, then one per cycle while m_tready is high
//  s_tready is low from merge acceptance until the last result is registered
//  reset clears state, counts, pointers and m_tvalid; memory stays undefined until written
//  a stalled output holds the result register and re-reads the same heads
`timescale 1ns / 1ps

module merge_two_sorted_lists #(
    parameter int LIST_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] merged_value
    output logic        m_tlast
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic                         wr_en_a;
    logic                         wr_en_b;
    logic [AW-1:0]                wr_addr_a;
    logic [AW-1:0]                wr_addr_b;
    logic [AW-1:0]                rd_addr_a;
    logic [AW-1:0]                rd_addr_b;
    logic [mtsl_pkg::VALUE_W-1:0] rd_data_a;
    logic [mtsl_pkg::VALUE_W-1:0] rd_data_b;

    mtsl_ram #(
        .WIDTH (mtsl_pkg::VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_first (
        .aclk    (aclk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr_a),
        .wr_data (s_tdata),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    mtsl_ram #(
        .WIDTH (mtsl_pkg::VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_second (
        .aclk    (aclk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr_b),
        .wr_data (s_tdata),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    mtsl_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_opcode  (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_value   (m_tdata),
        .m_last    (m_tlast),
        .wr_en_a   (wr_en_a),
        .wr_en_b   (wr_en_b),
        .wr_addr_a (wr_addr_a),
        .wr_addr_b (wr_addr_b),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

// ===== rtl/core/mtsl_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module mtsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mtsl_ctrl.sv =====
// append and merge sequencer: list counts, read pointers and output register
`timescale 1ns / 1ps

module mtsl_ctrl #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             s_tvalid,
    output logic                                             s_tready,
    input  logic [mtsl_pkg::OPCODE_W-1:0]                    s_opcode,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    output logic [mtsl_pkg::VALUE_W-1:0]                     m_value,
    output logic                                             m_last,
    output logic                                             wr_en_a,
    output logic                                             wr_en_b,
    output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] wr_addr_a,
    output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] wr_addr_b,
    output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] rd_addr_a,
    output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] rd_addr_b,
    input  logic [mtsl_pkg::VALUE_W-1:0]                     rd_data_a,
    input  logic [mtsl_pkg::VALUE_W-1:0]                     rd_data_b
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    mtsl_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;

    logic                          m_valid_reg, m_valid_next;
    logic [mtsl_pkg::VALUE_W-1:0]  m_value_reg, m_value_next;
    logic                          m_last_reg, m_last_next;

    logic          in_fire;
    logic          out_free;
    logic          take_b;
    logic          is_last;
    logic [CW:0]   total;
    logic [CW:0]   emitted;

    assign s_tready = (state_reg == mtsl_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign total    = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign emitted  = {1'b0, idx_a_reg} + {1'b0, idx_b_reg} + (CW + 1)'(1);
    assign is_last  = (emitted == total);

    // second list wins ties; an exhausted first list always yields to the second
    assign take_b = (idx_b_reg < cnt_b_reg) &&
                    ((idx_a_reg >= cnt_a_reg) ||
                     ($signed(rd_data_b) <= $signed(rd_data_a)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mtsl_pkg::ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            idx_a_reg   <= '0;
            idx_b_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            idx_a_reg   <= idx_a_next;
            idx_b_reg   <= idx_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        idx_a_next   = idx_a_reg;
        idx_b_next   = idx_b_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        wr_en_a      = 1'b0;
        wr_en_b      = 1'b0;

        case (state_reg)
            mtsl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (s_opcode)
                        mtsl_pkg::OP_APPEND_FIRST: begin
                            if (cnt_a_reg < FULL) begin
                                wr_en_a    = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end
                        end
                        mtsl_pkg::OP_APPEND_SECOND: begin
                            if (cnt_b_reg < FULL) begin
                                wr_en_b    = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end
                        end
                        mtsl_pkg::OP_MERGE: begin
                            if (total != '0) begin
                                state_next = mtsl_pkg::ST_MERGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mtsl_pkg::ST_MERGE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = is_last;
                    if (take_b) begin
                        m_value_next = rd_data_b;
                        idx_b_next   = idx_b_reg + CW'(1);
                    end else begin
                        m_value_next = rd_data_a;
                        idx_a_next   = idx_a_reg + CW'(1);
                    end
                    if (is_last) begin
                        state_next = mtsl_pkg::ST_IDLE;
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        idx_a_next = '0;
                        idx_b_next = '0;
                    end
                end
            end
            default: begin
                state_next = mtsl_pkg::ST_IDLE;
            end
        endcase
    end

    // read at the next pointer so the head of each list is ready in the next cycle
    assign rd_addr_a = idx_a_next[AW-1:0];
    assign rd_addr_b = idx_b_next[AW-1:0];
    assign wr_addr_a = cnt_a_reg[AW-1:0];
    assign wr_addr_b = cnt_b_reg[AW-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_last   = m_last_reg;

endmodule
